### design/ae16_pkg.sv
package ae16_pkg;

    localparam int TOTAL_W       = 14;
    localparam int CNT_W         = 16;
    localparam int CODE_BITS_DEF = 16;
    localparam int MAX_RES       = 16;
    localparam int NRES_W        = 5;
    localparam logic [CNT_W-1:0] PEND_MAX = 16'hFFFF;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_RENORM
    } back_state_t;

    typedef struct packed {
        logic               mode;
        logic [TOTAL_W-1:0] cl;
        logic [TOTAL_W-1:0] ch;
    } sym_t;

    typedef struct packed {
        logic             code_bit;
        logic [CNT_W-1:0] follow_count;
        logic             follow_overflow;
        logic             last;
    } res_t;

endpackage

### design/arithmetic_encoder_16bit_unit.sv
// channel | ports                      | accepted when
// input   | s_valid/s_ready, s_*       | s_valid && s_ready
// result  | m_valid/m_ready, m_*       | m_valid && m_ready
// config  | cfg_wr_en, cfg_wr_data     | cfg_wr_en
// Encode request: an issue state, a multiply state, a divide state (two restoring
// dividers side by side), then a renormalization state with one step per shift and a
// closing step that releases the last result.
// Finish request: handled in the idle state. A 2-deep queue lets input run ahead of the back end.
// Reset is synchronous, aresetn low; total count returns to 1.
// A stalled result port freezes the back end only when an emitted bit or the closing
// step finds both result registers full, or a finish request finds the output register full.
module arithmetic_encoder_16bit_unit #(
    parameter int CODE_BITS = ae16_pkg::CODE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ae16_pkg::TOTAL_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [ae16_pkg::TOTAL_W-1:0] s_cum_low,
    input  logic [ae16_pkg::TOTAL_W-1:0] s_cum_high,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_code_bit,
    output logic [ae16_pkg::CNT_W-1:0]   m_follow_count,
    output logic                         m_follow_overflow,
    output logic                         m_last
);
    logic [ae16_pkg::TOTAL_W-1:0] total_reg, total_eff;
    logic                         head_valid, pop;
    ae16_pkg::sym_t               head;
    ae16_pkg::res_t               res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= ae16_pkg::TOTAL_W'(1);
        end else if (cfg_wr_en) begin
            total_reg <= cfg_wr_data;
        end
    end

    // zero total acts as one
    assign total_eff = (total_reg == '0) ? ae16_pkg::TOTAL_W'(1) : total_reg;

    ae16_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_cum_low(s_cum_low), .s_cum_high(s_cum_high), .total(total_eff),
        .head_valid(head_valid), .head(head), .pop(pop)
    );

    ae16_back #(.CODE_BITS(CODE_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .total(total_eff),
        .head_valid(head_valid), .head(head), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(res)
    );

    assign m_code_bit        = res.code_bit;
    assign m_follow_count    = res.follow_count;
    assign m_follow_overflow = res.follow_overflow;
    assign m_last            = res.last;

endmodule

### design/ae16_div.sv
module ae16_div #(
    parameter int DW = 31
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [DW-1:0]                dividend,
    input  logic [ae16_pkg::TOTAL_W-1:0] divisor,
    output logic                         busy,
    output logic [DW-1:0]                quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [ae16_pkg::TOTAL_W-1:0] rem_reg, rem_next;
    logic [DW-1:0]                quo_reg, quo_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [ae16_pkg::TOTAL_W:0]   sh;
    logic [ae16_pkg::TOTAL_W:0]   diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        sh       = {rem_reg, quo_reg[DW-1]};
        diff     = sh - {1'b0, divisor};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CW'(DW);
        end else if (cnt_reg != '0) begin
            if (sh >= {1'b0, divisor}) begin
                rem_next = diff[ae16_pkg::TOTAL_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = sh[ae16_pkg::TOTAL_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

### design/ae16_front.sv
module ae16_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [ae16_pkg::TOTAL_W-1:0] s_cum_low,
    input  logic [ae16_pkg::TOTAL_W-1:0] s_cum_high,
    input  logic [ae16_pkg::TOTAL_W-1:0] total,
    output logic                         head_valid,
    output ae16_pkg::sym_t               head,
    input  logic                         pop
);
    ae16_pkg::sym_t               q_reg [2];
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         wr_reg, wr_next;
    logic                         rd_reg, rd_next;
    logic                         push;
    logic [ae16_pkg::TOTAL_W-1:0] ch_a, ch_b, cl_a;
    ae16_pkg::sym_t               sym;

    // clamp bounds into the valid sub-range (total is never zero here)
    always_comb begin
        ch_a = (s_cum_high > total) ? total : s_cum_high;
        ch_b = (ch_a == '0) ? ae16_pkg::TOTAL_W'(1) : ch_a;
        cl_a = (s_cum_low > ch_b - 1'b1) ? ch_b - 1'b1 : s_cum_low;
        sym.mode = s_mode;
        sym.cl   = cl_a;
        sym.ch   = ch_b;
    end

    assign s_ready    = (cnt_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_reg];

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
        end
        if (push) begin
            q_reg[wr_reg] <= sym;
        end
    end

endmodule

### design/ae16_back.sv
module ae16_back #(
    parameter int CODE_BITS = ae16_pkg::CODE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ae16_pkg::TOTAL_W-1:0] total,
    input  logic                         head_valid,
    input  ae16_pkg::sym_t               head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ae16_pkg::res_t               m_res
);
    localparam int CB = CODE_BITS;
    localparam int DW = CB + 1 + ae16_pkg::TOTAL_W;
    localparam logic [CB-1:0] TOP  = {CB{1'b1}};
    localparam logic [CB-1:0] HALF = CB'(1) << (CB - 1);
    localparam logic [CB-1:0] Q1   = CB'(1) << (CB - 2);
    localparam logic [CB-1:0] Q3   = HALF + Q1;

    ae16_pkg::back_state_t state_reg, state_next;
    logic [CB-1:0]                lo_reg, lo_next, hi_reg, hi_next;
    logic [ae16_pkg::CNT_W-1:0]   pend_reg, pend_next, pend_inc;
    logic [ae16_pkg::TOTAL_W-1:0] cl_reg, cl_next, ch_reg, ch_next;
    logic [CB:0]                  range_reg, range_next;
    logic [ae16_pkg::NRES_W-1:0]  n_reg, n_next;
    logic                         hold_v_reg, hold_v_next;
    ae16_pkg::res_t               hold_reg, hold_next;
    logic                         out_v_reg, out_v_next;
    ae16_pkg::res_t               out_reg, out_next;

    logic          out_free, div_start, lo_busy, hi_busy;
    logic [DW-1:0] q_lo, q_hi;
    logic [CB:0]   sum_lo, sum_hi;
    logic          e0, e1, mid, at_max;

    assign out_free = !out_v_reg || m_ready;
    assign pend_inc = (pend_reg == ae16_pkg::PEND_MAX) ? pend_reg : pend_reg + 1'b1;
    assign at_max   = (n_reg == ae16_pkg::NRES_W'(ae16_pkg::MAX_RES));
    assign e0       = !at_max && (hi_reg < HALF);
    assign e1       = !at_max && !e0 && (lo_reg >= HALF);
    assign mid      = !at_max && !e0 && !e1 && (lo_reg >= Q1) && (hi_reg < Q3);
    assign sum_lo   = {1'b0, lo_reg} + q_lo[CB:0];
    assign sum_hi   = {1'b0, lo_reg} + q_hi[CB:0] - 1'b1;

    ae16_div #(.DW(DW)) u_div_lo (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(DW'(cl_reg) * DW'(range_reg)), .divisor(total),
        .busy(lo_busy), .quotient(q_lo)
    );

    ae16_div #(.DW(DW)) u_div_hi (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(DW'(ch_reg) * DW'(range_reg)), .divisor(total),
        .busy(hi_busy), .quotient(q_hi)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ae16_pkg::B_IDLE: begin
                if (head_valid && head.mode == ae16_pkg::MODE_ENCODE) begin
                    state_next = ae16_pkg::B_MUL;
                end
            end
            ae16_pkg::B_MUL: state_next = ae16_pkg::B_DIV;
            ae16_pkg::B_DIV: begin
                if (!lo_busy && !hi_busy) begin
                    state_next = ae16_pkg::B_RENORM;
                end
            end
            ae16_pkg::B_RENORM: begin
                if (!e0 && !e1 && !mid && (!hold_v_reg || out_free)) begin
                    state_next = ae16_pkg::B_IDLE;
                end
            end
            default: state_next = ae16_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pend_next   = pend_reg;
        cl_next     = cl_reg;
        ch_next     = ch_reg;
        range_next  = range_reg;
        n_next      = n_reg;
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        out_v_next  = out_v_reg && !m_ready;
        out_next    = out_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            ae16_pkg::B_IDLE: begin
                if (head_valid && head.mode == ae16_pkg::MODE_ENCODE) begin
                    pop        = 1'b1;
                    cl_next    = head.cl;
                    ch_next    = head.ch;
                    range_next = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
                end else if (head_valid && out_free) begin
                    // finish: one more pending bit, then the closing bit
                    pop                      = 1'b1;
                    out_v_next               = 1'b1;
                    out_next.code_bit        = (lo_reg >= Q1);
                    out_next.follow_count    = pend_inc;
                    out_next.follow_overflow = (pend_inc == ae16_pkg::PEND_MAX);
                    out_next.last            = 1'b1;
                    lo_next                  = '0;
                    hi_next                  = TOP;
                    pend_next                = '0;
                end
            end
            ae16_pkg::B_MUL: begin
                div_start = 1'b1;
            end
            ae16_pkg::B_DIV: begin
                if (!lo_busy && !hi_busy) begin
                    lo_next = sum_lo[CB-1:0];
                    hi_next = (q_hi <= q_lo) ? sum_lo[CB-1:0] : sum_hi[CB-1:0];
                    n_next  = '0;
                end
            end
            ae16_pkg::B_RENORM: begin
                if (e0 || e1) begin
                    if (!hold_v_reg || out_free) begin
                        if (hold_v_reg) begin
                            out_v_next = 1'b1;
                            out_next   = hold_reg;
                        end
                        hold_v_next               = 1'b1;
                        hold_next.code_bit        = e1;
                        hold_next.follow_count    = pend_reg;
                        hold_next.follow_overflow = (pend_reg == ae16_pkg::PEND_MAX);
                        hold_next.last            = 1'b0;
                        pend_next                 = '0;
                        n_next                    = n_reg + 1'b1;
                        lo_next                   = {lo_reg[CB-2:0], 1'b0};
                        hi_next                   = {hi_reg[CB-2:0], 1'b1};
                    end
                end else if (mid) begin
                    pend_next = pend_inc;
                    lo_next   = {lo_reg[CB-2:0] - Q1[CB-2:0], 1'b0};
                    hi_next   = {hi_reg[CB-2:0] - Q1[CB-2:0], 1'b1};
                end else if (hold_v_reg && out_free) begin
                    out_v_next    = 1'b1;
                    out_next      = hold_reg;
                    out_next.last = 1'b1;
                    hold_v_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ae16_pkg::B_IDLE;
            lo_reg     <= '0;
            hi_reg     <= TOP;
            pend_reg   <= '0;
            n_reg      <= '0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            pend_reg   <= pend_next;
            n_reg      <= n_next;
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
        cl_reg    <= cl_next;
        ch_reg    <= ch_next;
        range_reg <= range_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

    assign m_valid = out_v_reg;
    assign m_res   = out_reg;

    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ae16_pkg::B_IDLE |-> !hold_v_reg)
        else $error("held result left over in idle");
    a_n_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= ae16_pkg::NRES_W'(ae16_pkg::MAX_RES))
        else $error("result count beyond limit");
    a_interval_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ae16_pkg::B_RENORM |-> lo_reg <= hi_reg)
        else $error("interval inverted");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == ae16_pkg::B_IDLE && head_valid)
        else $error("request taken outside idle");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE = 200;  // settling wait after the expected results have drained

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [ae16_pkg::TOTAL_W-1:0] cfg_wr_data = '0;
    logic s_valid = 0;
    logic s_mode = ae16_pkg::MODE_ENCODE;
    logic [ae16_pkg::TOTAL_W-1:0] s_cum_low = '0;
    logic [ae16_pkg::TOTAL_W-1:0] s_cum_high = '0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 0;
    logic m_code_bit;
    logic [ae16_pkg::CNT_W-1:0] m_follow_count;
    logic m_follow_overflow;
    logic m_last;

    arithmetic_encoder_16bit_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_cum_low(s_cum_low), .s_cum_high(s_cum_high),
        .m_valid(m_valid), .m_ready(m_ready), .m_code_bit(m_code_bit),
        .m_follow_count(m_follow_count), .m_follow_overflow(m_follow_overflow),
        .m_last(m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // encoder state mirror
    longint unsigned iv_low, iv_high;
    int unsigned pend;
    logic [ae16_pkg::TOTAL_W-1:0] tot_reg;
    ae16_pkg::res_t bits_q[$];
    int mismatches = 0;
    int n_requests = 0;
    int n_bits = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    function automatic void code_bit_out(ref ae16_pkg::res_t q[$], input logic b);
        ae16_pkg::res_t r;
        r.code_bit = b;
        r.follow_count = pend[ae16_pkg::CNT_W-1:0];
        r.follow_overflow = (pend >= 65535);
        r.last = 1'b0;
        q.insert(q.size(), r);
        pend = 0;
    endfunction

    function automatic void bump_pending();
        if (pend < 65535) pend++;
    endfunction

    // appends the code bits this request produces to the queue and advances the mirror
    function automatic void encode_symbol(input logic md,
                                          input logic [ae16_pkg::TOTAL_W-1:0] cl_in,
                                          input logic [ae16_pkg::TOTAL_W-1:0] ch_in,
                                          ref ae16_pkg::res_t q[$]);
        longint unsigned top, q1, half, q3, t, ch, cl, rng, lo_off, hi_off, lo;
        int n;
        top = 64'hFFFF;
        q1 = 64'h4000;
        half = 64'h8000;
        q3 = 64'hC000;
        n = 0;
        if (md == ae16_pkg::MODE_FINISH) begin
            bump_pending();
            code_bit_out(q, iv_low < q1 ? 1'b0 : 1'b1);
            q[q.size()-1].last = 1'b1;
            iv_low = 0;
            iv_high = top;
            pend = 0;
            return;
        end
        t = (tot_reg == 0) ? 1 : tot_reg;
        ch = ch_in;
        cl = cl_in;
        if (ch > t) ch = t;
        if (ch == 0) ch = 1;
        if (cl > ch - 1) cl = ch - 1;
        lo = iv_low;
        rng = iv_high - lo + 1;
        lo_off = cl * rng / t;
        hi_off = ch * rng / t;
        iv_low = lo + lo_off;
        iv_high = (hi_off <= lo_off) ? iv_low : lo + hi_off - 1;
        while (n < ae16_pkg::MAX_RES) begin
            if (iv_high < half) begin
                code_bit_out(q, 1'b0);
                n++;
            end else if (iv_low >= half) begin
                code_bit_out(q, 1'b1);
                n++;
                iv_low -= half;
                iv_high -= half;
            end else if (iv_low >= q1 && iv_high < q3) begin
                bump_pending();
                iv_low -= q1;
                iv_high -= q1;
            end else begin
                break;
            end
            iv_low = (iv_low << 1) & top;
            iv_high = ((iv_high << 1) | 1) & top;
        end
        if (n > 0) q[q.size()-1].last = 1'b1;
    endfunction

    // result checker
    always @(posedge aclk) begin
        ae16_pkg::res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_code_bit, m_follow_count, m_follow_overflow, m_last};
            n_bits++;
            if (bits_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = bits_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 0;
            hold_cycles--;
        end else begin
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic drain();
        while (bits_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_total(input logic [ae16_pkg::TOTAL_W-1:0] v);
        drain();
        cfg_wr_en = 1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 0;
        tot_reg = v;
    endtask

    // one request; leaves valid high so back-to-back requests stay seamless
    task automatic send(input logic md, input logic [ae16_pkg::TOTAL_W-1:0] cl,
                        input logic [ae16_pkg::TOTAL_W-1:0] ch,
                        input bit typed, input ae16_pkg::res_t typed_res);
        ae16_pkg::res_t scratch[$];
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_mode = md;
        s_cum_low = cl;
        s_cum_high = ch;
        do @(posedge aclk); while (!s_ready);
        n_requests++;
        if (typed) begin
            encode_symbol(md, cl, ch, scratch);
            bits_q.insert(bits_q.size(), typed_res);
        end else begin
            encode_symbol(md, cl, ch, bits_q);
        end
        @(negedge aclk);
    endtask

    typedef struct {
        logic [ae16_pkg::TOTAL_W-1:0] tot;
        logic md;
        logic [ae16_pkg::TOTAL_W-1:0] cl;
        logic [ae16_pkg::TOTAL_W-1:0] ch;
        bit typed;
        ae16_pkg::res_t res;
    } row_t;

    row_t dir_rows[] = '{
        // finish straight after reset: low is zero, one follow bit
        '{14'd1, ae16_pkg::MODE_FINISH, 14'd0, 14'd0, 1'b1, '{1'b0, 16'd1, 1'b0, 1'b1}},
        '{14'd1, ae16_pkg::MODE_ENCODE, 14'd0, 14'd1, 1'b0, '0},          // full range
        '{14'd1, ae16_pkg::MODE_ENCODE, 14'h3FFF, 14'h3FFF, 1'b0, '0},    // both clamped
        '{14'd1, ae16_pkg::MODE_ENCODE, 14'd0, 14'd0, 1'b0, '0},          // zero cum_high
        '{14'd0, ae16_pkg::MODE_ENCODE, 14'd0, 14'd1, 1'b0, '0},          // zero total
        '{14'd0, ae16_pkg::MODE_FINISH, 14'h3FFF, 14'h3FFF, 1'b1,
          '{1'b0, 16'd1, 1'b0, 1'b1}},
        '{14'h3FFF, ae16_pkg::MODE_ENCODE, 14'd0, 14'd1, 1'b0, '0},       // tiny low symbol
        '{14'h3FFF, ae16_pkg::MODE_ENCODE, 14'h3FFE, 14'h3FFF, 1'b0, '0}, // tiny high symbol
        '{14'h3FFF, ae16_pkg::MODE_ENCODE, 14'h1FFF, 14'h2000, 1'b0, '0}, // middle, pending
        '{14'h3FFF, ae16_pkg::MODE_ENCODE, 14'h2000, 14'h1000, 1'b0, '0}, // low above high
        '{14'h3FFF, ae16_pkg::MODE_ENCODE, 14'h1555, 14'h2AAA, 1'b0, '0},
        '{14'h3FFF, ae16_pkg::MODE_ENCODE, 14'd0, 14'h3FFF, 1'b0, '0},
        '{14'h3FFF, ae16_pkg::MODE_FINISH, 14'd0, 14'd0, 1'b0, '0},
        '{14'd3, ae16_pkg::MODE_ENCODE, 14'd1, 14'd2, 1'b0, '0},          // empty after rounding?
        '{14'd3, ae16_pkg::MODE_ENCODE, 14'd2, 14'd3, 1'b0, '0},
        '{14'd3, ae16_pkg::MODE_ENCODE, 14'd0, 14'd1, 1'b0, '0},
        '{14'd3, ae16_pkg::MODE_FINISH, 14'd0, 14'd0, 1'b0, '0},
        '{14'h2AAA, ae16_pkg::MODE_ENCODE, 14'h1555, 14'h1556, 1'b0, '0},
        '{14'h2AAA, ae16_pkg::MODE_ENCODE, 14'h2AA9, 14'h2AAA, 1'b0, '0},
        '{14'h2AAA, ae16_pkg::MODE_FINISH, 14'd0, 14'd0, 1'b0, '0}
    };

    task automatic random_item();
        logic [ae16_pkg::TOTAL_W-1:0] cl, ch;
        int t;
        t = (tot_reg == 0) ? 1 : tot_reg;
        if ($urandom_range(11) == 0) begin
            send(ae16_pkg::MODE_FINISH, ae16_pkg::TOTAL_W'($urandom),
                 ae16_pkg::TOTAL_W'($urandom), 1'b0, '0);
        end else if ($urandom_range(9) == 0) begin
            // unconstrained bounds
            send(ae16_pkg::MODE_ENCODE, ae16_pkg::TOTAL_W'($urandom),
                 ae16_pkg::TOTAL_W'($urandom), 1'b0, '0);
        end else begin
            ch = ae16_pkg::TOTAL_W'($urandom_range(t, 1));
            cl = ae16_pkg::TOTAL_W'($urandom_range(ch - 1, 0));
            send(ae16_pkg::MODE_ENCODE, cl, ch, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int items, input int idle, input int stall,
                             input int hold, input logic [ae16_pkg::TOTAL_W-1:0] tot);
        set_total(tot);
        idle_pct = idle;
        stall_pct = stall;
        if (hold > 0) hold_cycles = hold;
        repeat (items) random_item();
        s_valid = 0;
    endtask

    initial begin
        row_t r;
        tot_reg = 14'd1;
        iv_low = 0;
        iv_high = 64'hFFFF;
        pend = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.tot != tot_reg) begin
                s_valid = 0;
                set_total(r.tot);
            end
            send(r.md, r.cl, r.ch, r.typed, r.res);
        end
        s_valid = 0;

        run_phase(70, 0, 0, 0, 14'h3FFF);
        run_phase(40, 71, 0, 0, ae16_pkg::TOTAL_W'($urandom_range(16383, 1)));
        // long receiver hold-off so the input queue backs up
        run_phase(40, 0, 0, 600, 14'd100);
        // sender waits for the stream to empty between phases
        drain();
        run_phase(60, 71, 0, 0, 14'd7);
        run_phase(80, 0, 71, 0, ae16_pkg::TOTAL_W'($urandom_range(16383, 1)));
        run_phase(60, 11, 11, 0, 14'd2);

        drain();
        $display("%0d requests across totals 0..16383, %0d code bits, mixed stall patterns",
                 n_requests, n_bits);
        if (mismatches == 0 && bits_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, bits_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
